// File: rtl/core/vpw_pkg.sv
// Shared constants, types and helpers for the vertex projection block.
package vpw_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

	typedef enum logic [1:0] {
		OP_LOAD_MODEL = 2'd0,
		OP_LOAD_PROJ  = 2'd1,
		OP_PROJECT    = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	localparam logic [1:0] REG_VP_X = 2'd0;
	localparam logic [1:0] REG_VP_Y = 2'd1;
	localparam logic [1:0] REG_VP_W = 2'd2;
	localparam logic [1:0] REG_VP_H = 2'd3;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		logic signed [79:0] hi;
		logic signed [79:0] lo;
		hi = 80'sd2147483647;
		lo = -80'sd2147483648;
		if (v > hi) return 32'sh7FFFFFFF;
		else if (v < lo) return 32'sh80000000;
		else return v[31:0];
	endfunction

	// Divider request and response between the top level and the divider.
	typedef struct packed {
		logic start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] quot;
	} div_rsp_t;

endpackage

// File: rtl/core/vpw_div.sv
// Restoring divider: (num * one) / den, truncated toward zero, saturated to 32 bits.
module vpw_div import vpw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int NW = 32 + FRAC_BITS;

	logic [NW-1:0] num_q;
	logic [32:0]   rem_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic          busy_q;
	logic [5:0]    cnt_q;
	logic [33:0]   trial;
	logic [32:0]   shifted;
	logic [NW-1:0] un;
	logic signed [79:0] sq;

	assign un = req.num[31] ? NW'(-(64'(signed'(req.num)) <<< FRAC_BITS))
	                        : NW'(64'(signed'(req.num)) <<< FRAC_BITS);
	assign shifted = {rem_q[31:0], num_q[NW-1]};
	assign trial = {1'b0, shifted} - {2'b0, den_q};
	assign sq = neg_q ? -80'(signed'({1'b0, num_q})) : 80'(signed'({1'b0, num_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				num_q  <= un;
				rem_q  <= '0;
				den_q  <= req.den[31] ? 32'(-33'(signed'(req.den))) : req.den;
				neg_q  <= req.num[31] ^ req.den[31];
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				// one quotient bit a cycle, shifted in at the bottom of num_q
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					num_q <= {num_q[NW-2:0], 1'b0};
				end
				if (cnt_q == 6'(NW - 1)) busy_q <= 1'b0;
				cnt_q <= cnt_q + 6'd1;
			end else if (cnt_q == 6'(NW)) begin
				rsp.quot <= sat32(sq);
				rsp.done <= 1'b1;
				cnt_q    <= '0;
			end
		end
	end

endmodule

// File: rtl/core/vertex_project_to_window.sv
// Top level: matrix store, shared multiply-add unit, viewport mapping.
//
// Usage: items enter on in_valid/in_ready. Operation 0 or 1 writes one entry of
// the model or projection matrix and yields no result; operation 3 is dropped.
// Operation 2 projects (obj_x, obj_y, obj_z, 1) and yields one result on
// out_valid/out_ready: projected_ok and win_x/win_y/win_z in Q16.16.
// A load writes its entry when it is accepted. A projection raises out_valid
// after eight row sums (four reads through one synchronous memory port into
// one 32x32 multiplier, then the read, multiply and accumulate registers
// drain), then three divisions by clip w in a one-bit-a-cycle divider (none
// when clip w is zero). One projection is in work at a time; the result sits
// in an output register and the next item is accepted while it waits to be
// taken. Viewport registers are to be written through cfg_we/cfg_index/cfg_data
// by the user only while idle; the block itself does not enforce it. Reset
// loads both matrices with identity (through valid bits, no clear pass),
// viewport 0,0 640x480. A stalled receiver holds the result and blocks the
// next projection from completing.
module vertex_project_to_window import vpw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [3:0]         entry_index,
	input  logic signed [31:0] entry_value,
	input  logic signed [31:0] obj_x,
	input  logic signed [31:0] obj_y,
	input  logic signed [31:0] obj_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               projected_ok,
	output logic signed [31:0] win_x,
	output logic signed [31:0] win_y,
	output logic signed [31:0] win_z,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_MAC, S_DIV, S_MAP, S_OUT} state_t;

	localparam int LW = FRAC_BITS + 2;

	state_t state_q;

	logic signed [15:0] vp_x_q, vp_y_q;
	logic [14:0]        vp_w_q, vp_h_q;

	// Both matrices in one memory: address {matrix, entry}.
	logic [31:0] mem [32];
	logic [31:0] valid_q;
	logic [31:0] rd_data_s1;
	logic        rd_valid_s1;
	logic [4:0]  rd_addr;
	logic        rd_en;
	logic [4:0]  rd_addr_s1;

	logic signed [31:0] vec_q [4];
	logic signed [31:0] eye_q [4];
	logic               pass_q;
	logic [1:0]         row_q, col_q;
	logic               issued_q;
	logic               step_vld_s1;
	logic [1:0]         step_col_s1;
	logic               step_last_s1;
	logic signed [63:0] prod_s2;
	logic               prod_vld_s2;
	logic               prod_last_s2;
	logic               acc_last_s3;
	logic signed [79:0] hi_sum_q;
	logic [LW-1:0]      lo_sum_q;
	logic signed [31:0] row_res;
	logic [1:0]         div_cnt_q;
	logic signed [31:0] quo_q [3];
	logic               wait_div_q;
	div_req_t           dreq;
	div_rsp_t           drsp;
	logic signed [31:0] elem;
	logic signed [63-FRAC_BITS:0] hi_p;
	logic [FRAC_BITS-1:0] lo_p;
	logic signed [33:0] tx, ty, tz;
	logic signed [79:0] wx, wy, wz;

	vpw_div u_div (.clk, .arst_n, .req(dreq), .rsp(drsp));

	assign in_ready = (state_q == S_IDLE);
	assign rd_en    = (state_q == S_MAC) && !issued_q;
	assign rd_addr  = {pass_q, col_q, row_q};

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && (operation == OP_LOAD_MODEL || operation == OP_LOAD_PROJ))
			mem[{operation[0], entry_index}] <= entry_value;
		if (rd_en) rd_data_s1 <= mem[rd_addr];
	end

	// Entries never loaded read as identity.
	assign elem = rd_valid_s1 ? signed'(rd_data_s1)
	              : ((rd_addr_s1[3:2] == rd_addr_s1[1:0]) ? ONE_FX : 32'sd0);
	assign hi_p = prod_s2[63:FRAC_BITS];
	assign lo_p = prod_s2[FRAC_BITS-1:0];
	assign row_res = sat32(hi_sum_q + 80'(signed'({1'b0, lo_sum_q >> FRAC_BITS})));

	assign dreq.start = (state_q == S_DIV) && !wait_div_q;
	assign dreq.num   = quo_q[div_cnt_q];
	assign dreq.den   = eye_q[3];

	assign tx = 34'(quo_q[0]) + 34'(ONE_FX);
	assign ty = 34'(quo_q[1]) + 34'(ONE_FX);
	assign tz = 34'(quo_q[2]) + 34'(ONE_FX);
	assign wx = ((80'(tx) * 80'(signed'({1'b0, vp_w_q}))) >>> 1)
	            + (80'(vp_x_q) <<< FRAC_BITS);
	assign wy = ((80'(ty) * 80'(signed'({1'b0, vp_h_q}))) >>> 1)
	            + (80'(vp_y_q) <<< FRAC_BITS);
	assign wz = 80'(tz) >>> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			out_valid    <= 1'b0;
			vp_x_q       <= '0;
			vp_y_q       <= '0;
			vp_w_q       <= 15'd640;
			vp_h_q       <= 15'd480;
			step_vld_s1  <= 1'b0;
			prod_vld_s2  <= 1'b0;
			step_last_s1 <= 1'b0;
			prod_last_s2 <= 1'b0;
			acc_last_s3  <= 1'b0;
			issued_q     <= 1'b0;
			wait_div_q   <= 1'b0;
			pass_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VP_X: vp_x_q <= signed'(cfg_data);
					REG_VP_Y: vp_y_q <= signed'(cfg_data);
					REG_VP_W: vp_w_q <= cfg_data[14:0];
					REG_VP_H: vp_h_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) out_valid <= 1'b0;

			// read -> multiply -> accumulate pipeline
			step_vld_s1  <= rd_en;
			step_col_s1  <= col_q;
			step_last_s1 <= rd_en && col_q == 2'd3;
			rd_addr_s1   <= rd_addr;
			rd_valid_s1  <= valid_q[rd_addr];
			prod_vld_s2  <= step_vld_s1;
			prod_last_s2 <= step_vld_s1 && step_last_s1;
			acc_last_s3  <= prod_last_s2;
			if (step_vld_s1) prod_s2 <= vec_q[step_col_s1] * elem;
			if (prod_vld_s2) begin
				hi_sum_q <= hi_sum_q + 80'(hi_p);
				lo_sum_q <= lo_sum_q + LW'(lo_p);
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						case (operation)
							OP_LOAD_MODEL, OP_LOAD_PROJ:
								valid_q[{operation[0], entry_index}] <= 1'b1;
							OP_PROJECT: begin
								vec_q[0] <= obj_x;
								vec_q[1] <= obj_y;
								vec_q[2] <= obj_z;
								vec_q[3] <= ONE_FX;
								pass_q   <= 1'b0;
								row_q    <= '0;
								col_q    <= '0;
								hi_sum_q <= '0;
								lo_sum_q <= '0;
								state_q  <= S_MAC;
							end
							default: ;
						endcase
					end
				end
				S_MAC: begin
					if (rd_en) begin
						col_q <= col_q + 2'd1;
						if (col_q == 2'd3) issued_q <= 1'b1;
					end
					// row finished once its last product has been summed
					if (acc_last_s3) begin
						eye_q[row_q] <= row_res;
						hi_sum_q     <= '0;
						lo_sum_q     <= '0;
						row_q        <= row_q + 2'd1;
						col_q        <= '0;
						issued_q     <= 1'b0;
						if (row_q == 2'd3) begin
							if (pass_q) begin
								quo_q[0]  <= eye_q[0];
								quo_q[1]  <= eye_q[1];
								quo_q[2]  <= eye_q[2];
								div_cnt_q <= '0;
								state_q   <= (row_res == 32'sd0) ? S_MAP : S_DIV;
							end else begin
								vec_q[0] <= eye_q[0];
								vec_q[1] <= eye_q[1];
								vec_q[2] <= eye_q[2];
								vec_q[3] <= row_res;
								pass_q   <= 1'b1;
							end
						end
					end
				end
				S_DIV: begin
					if (!wait_div_q) wait_div_q <= 1'b1;
					else if (drsp.done) begin
						quo_q[div_cnt_q] <= drsp.quot;
						wait_div_q       <= 1'b0;
						div_cnt_q        <= div_cnt_q + 2'd1;
						if (div_cnt_q == 2'd2) state_q <= S_MAP;
					end
				end
				S_MAP: begin
					if (!out_valid) begin
						projected_ok <= (eye_q[3] != 32'sd0);
						win_x <= (eye_q[3] == 32'sd0) ? 32'sd0 : sat32(wx);
						win_y <= (eye_q[3] == 32'sd0) ? 32'sd0 : sat32(wy);
						win_z <= (eye_q[3] == 32'sd0) ? 32'sd0 : sat32(wz);
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(win_x) && $stable(win_z))
		else $error("result dropped while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("input taken while projecting");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !projected_ok |-> win_x == 32'sd0 && win_y == 32'sd0)
		else $error("failed projection carries nonzero window point");
`endif

endmodule
